[hw/rtl/assert_macros.svh]
// Assertion macros shared by the yEnc decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising edge of clk, quiet while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be true at a rising edge of clk.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/yenc_pkg.sv]
// Package with the codes, types and CRC function of the yEnc decoder.
`default_nettype none
package yenc_pkg;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_CHECK   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SIZE_ERR = 2'd1;
	localparam logic [1:0] STAT_PART_ERR = 2'd2;
	localparam logic [1:0] STAT_FILE_ERR = 2'd3;

	localparam logic CFG_MAIN_OFFSET   = 1'b0;
	localparam logic CFG_ESCAPE_OFFSET = 1'b1;

	localparam logic [7:0] CH_ESC = 8'h3D;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic [7:0] MAIN_OFFSET_RST   = 8'd42;
	localparam logic [7:0] ESCAPE_OFFSET_RST = 8'd64;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Controls for the escape tracker.
	typedef struct packed {
		logic take_byte;
		logic clear;
	} dec_ctl_t;

	// What the byte decoder makes of the current raw byte.
	typedef struct packed {
		logic       emit;
		logic [7:0] value;
	} dec_res_t;

	// Controls for the CRC and length accumulators.
	typedef struct packed {
		logic       byte_en;
		logic       check_en;
		logic       restart;
		logic [7:0] value;
	} acc_ctl_t;

	// Reflected CRC-32 update over one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/yenc_byte_decoder_with_crc_check.sv]
// Top level of the yEnc byte decoder with part and file CRC-32 checking.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_ready   kind, data_byte, multipart, expected_*
//   out      output     out_valid/out_ready decoded_byte, byte_valid, check_status,
//                                           check_valid
//   cfg      input      cfg_we (no stall)   cfg_index, cfg_data
//
// An accepted item sits in the input register, where the decoder
// and the accumulators handle it and any result moves into the output register.
// One item is taken per cycle unless a result stalls in the input register;
// the throughput is set by the single input stage. A result is on out in the
// cycle after its item is handled in the input register.
// Reset clears both registers' valid flags, the escape flag, both CRCs, the part
// length, and sets the offsets to 42 and 64.
// When a result waits on out_ready, an item that produces a result stalls in the
// input register and in_ready drops; items that give no result still pass.
`default_nettype none
`include "assert_macros.svh"
module yenc_byte_decoder_with_crc_check
	import yenc_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        multipart,
	input  wire logic [31:0] expected_part_size,
	input  wire logic [31:0] expected_part_crc,
	input  wire logic [31:0] expected_file_crc,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       decoded_byte,
	output logic             byte_valid,
	output logic [1:0]       check_status,
	output logic             check_valid
);

	// Offset registers; the user must write them only while the block is idle, which the block itself does not enforce.
	logic [7:0] main_offset_q;
	logic [7:0] escape_offset_q;

	// Input stage.
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  data_s1;
	logic        multipart_s1;
	logic [31:0] exp_size_s1;
	logic [31:0] exp_pcrc_s1;
	logic [31:0] exp_fcrc_s1;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  decoded_byte_q;
	logic        byte_valid_q;
	logic [1:0]  check_status_q;
	logic        check_valid_q;

	logic        is_data;
	logic        is_check;
	logic        is_restart;
	logic        has_result;
	logic        out_free;
	logic        advance;
	dec_ctl_t    dec_ctl;
	dec_res_t    dec_res;
	acc_ctl_t    acc_ctl;
	logic [1:0]  status;

	// Kind of the result that sits in the output register.
	logic        out_byte;
	logic        out_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_offset_q   <= MAIN_OFFSET_RST;
			escape_offset_q <= ESCAPE_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAIN_OFFSET:   main_offset_q   <= cfg_data;
				CFG_ESCAPE_OFFSET: escape_offset_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Decode the held item's kind. The reserved kind does nothing at all.
	assign is_data    = (kind_s1 == KIND_DATA);
	assign is_check   = (kind_s1 == KIND_CHECK);
	assign is_restart = (kind_s1 == KIND_RESTART);

	// A data byte gives a result only when it is not dropped, a part end always does.
	assign has_result = (is_data && dec_res.emit) || is_check;
	assign out_free   = !out_valid_q || out_ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign in_ready   = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1      <= kind;
			data_s1      <= data_byte;
			multipart_s1 <= multipart;
			exp_size_s1  <= expected_part_size;
			exp_pcrc_s1  <= expected_part_crc;
			exp_fcrc_s1  <= expected_file_crc;
		end
	end

	assign dec_ctl.take_byte = advance && is_data;
	assign dec_ctl.clear     = advance && (is_check || is_restart);

	yenc_dec u_dec (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (dec_ctl),
		.data_byte     (data_s1),
		.main_offset   (main_offset_q),
		.escape_offset (escape_offset_q),
		.res           (dec_res)
	);

	assign acc_ctl.byte_en  = advance && is_data && dec_res.emit;
	assign acc_ctl.check_en = advance && is_check;
	assign acc_ctl.restart  = advance && is_restart;
	assign acc_ctl.value    = dec_res.value;

	yenc_acc #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_acc (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctl                (acc_ctl),
		.multipart          (multipart_s1),
		.expected_part_size (exp_size_s1),
		.expected_part_crc  (exp_pcrc_s1),
		.expected_file_crc  (exp_fcrc_s1),
		.status             (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	// The status is sampled before the part end clears the accumulators.
	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			decoded_byte_q <= is_data ? dec_res.value : 8'd0;
			byte_valid_q   <= is_data;
			check_status_q <= is_check ? status : STAT_OK;
			check_valid_q  <= is_check;
		end
	end

	assign out_valid    = out_valid_q;
	assign decoded_byte = decoded_byte_q;
	assign byte_valid   = byte_valid_q;
	assign check_status = check_status_q;
	assign check_valid  = check_valid_q;

	assign out_byte  = out_valid_q && byte_valid_q;
	assign out_check = out_valid_q && check_valid_q;

	// Every result is either a byte or a check status, never both or neither.
	`ASSERT_CLK(a_one_result_kind, out_valid_q |-> (out_byte != out_check), "bad result kind")
	// A check result carries a zero byte.
	`ASSERT_NEVER(a_check_pad, out_check && (decoded_byte_q != 8'd0), "check byte not zero")
	// A byte result carries a zero status.
	`ASSERT_NEVER(a_byte_pad, out_byte && (check_status_q != STAT_OK), "byte status not zero")
	// The input side only stalls when an item is held and cannot leave.
	`ASSERT_NEVER(a_stall_reason, !in_ready && (!valid_s1 || out_free), "stall without cause")

endmodule
`default_nettype wire

[hw/rtl/yenc_dec.sv]
// Byte decoder: escape tracking, CR/LF dropping and offset subtraction.
`default_nettype none
`include "assert_macros.svh"
module yenc_dec
	import yenc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dec_ctl_t   ctl,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] main_offset,
	input  wire logic [7:0] escape_offset,
	output dec_res_t        res
);

	logic escape_q;

	always_comb begin
		res.emit  = escape_q || ((data_byte != CH_CR) && (data_byte != CH_LF) &&
			(data_byte != CH_ESC));
		res.value = escape_q ? 8'(data_byte - escape_offset - main_offset)
			: 8'(data_byte - main_offset);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
		end else if (ctl.clear) begin
			escape_q <= 1'b0;
		end else if (ctl.take_byte) begin
			escape_q <= !escape_q && (data_byte == CH_ESC);
		end
	end

	// A cleared part or file never carries an escape into the next byte.
	`ASSERT_CLK(a_escape_cleared, ctl.clear |=> !escape_q, "escape survived a clear")

endmodule
`default_nettype wire

[hw/rtl/yenc_acc.sv]
// CRC-32 and part length accumulators with the part end checks.
`default_nettype none
`include "assert_macros.svh"
module yenc_acc
	import yenc_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire acc_ctl_t    ctl,
	input  wire logic        multipart,
	input  wire logic [31:0] expected_part_size,
	input  wire logic [31:0] expected_part_crc,
	input  wire logic [31:0] expected_file_crc,
	output logic      [1:0]  status
);

	localparam int CMP_W = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

	logic [31:0]             part_crc_q;
	logic [31:0]             file_crc_q;
	logic [LENGTH_WIDTH-1:0] part_len_q;
	logic [CMP_W-1:0]        len_ext;
	logic [CMP_W-1:0]        exp_ext;

	assign len_ext = CMP_W'(part_len_q);
	assign exp_ext = CMP_W'(expected_part_size);

	always_comb begin
		status = STAT_OK;
		if (multipart && (len_ext != exp_ext)) begin
			status = STAT_SIZE_ERR;
		end else if (multipart && ((part_crc_q ^ CRC_INIT) != expected_part_crc)) begin
			status = STAT_PART_ERR;
		end else if ((expected_file_crc != 32'd0) &&
			((file_crc_q ^ CRC_INIT) != expected_file_crc)) begin
			status = STAT_FILE_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_crc_q <= CRC_INIT;
			file_crc_q <= CRC_INIT;
			part_len_q <= '0;
		end else if (ctl.restart) begin
			part_crc_q <= CRC_INIT;
			file_crc_q <= CRC_INIT;
			part_len_q <= '0;
		end else if (ctl.check_en) begin
			part_crc_q <= CRC_INIT;
			part_len_q <= '0;
		end else if (ctl.byte_en) begin
			part_crc_q <= crc32_byte(part_crc_q, ctl.value);
			file_crc_q <= crc32_byte(file_crc_q, ctl.value);
			if (part_len_q != '1) begin
				part_len_q <= part_len_q + 1'b1;
			end
		end
	end

	// A part end starts the next part from an empty count and a fresh CRC.
	`ASSERT_CLK(a_part_cleared, ctl.check_en |=> (part_len_q == '0) && (part_crc_q == CRC_INIT), "part state not cleared")
	// A restart also resets the file CRC.
	`ASSERT_CLK(a_file_cleared, ctl.restart |=> file_crc_q == CRC_INIT, "file CRC not cleared")

endmodule
`default_nettype wire

[sim/tb_yenc_byte_decoder_with_crc_check.sv]
// Self-checking testbench for the yEnc byte decoder with part and file CRC-32 checking.
`timescale 1ns / 1ps
module tb_yenc_byte_decoder_with_crc_check;
	import yenc_pkg::*;

	// Kind 3 has no meaning to the block, which must drop it without a trace.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Fields of a part-end item that are filled in from the running totals.
	// When a bit is set, the value in the item is XORed onto the true total,
	// so zero gives the correct value and a single set bit gives a near miss.
	localparam logic [2:0] FIX_SIZE = 3'b001;
	localparam logic [2:0] FIX_PCRC = 3'b010;
	localparam logic [2:0] FIX_FCRC = 3'b100;
	localparam logic [2:0] FIX_ALL  = 3'b111;

	localparam int LEN_W          = 32;
	localparam int IDLE_PCT       = 37;
	localparam int DRAIN_CYCLES   = 6;    // an item with no result never stalls in the input register
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS    = 125;
	localparam int NUM_PHASES     = 6;
	localparam int TIMEOUT_NS     = 4_000_000;

	// One input item, laid out as the block's input fields.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        multipart;
		logic [31:0] exp_size;
		logic [31:0] part_crc;
		logic [31:0] file_crc;
	} stim_t;

	// One result item, laid out as the block's output fields.
	typedef struct packed {
		logic [7:0] value;
		logic       byte_flag;
		logic [1:0] status;
		logic       check_flag;
	} res_t;

	// How a directed row gets its expected result.
	typedef enum {EXP_PREDICT, EXP_NONE, EXP_BYTE, EXP_STATUS} row_exp_t;

	typedef struct {
		stim_t      s;
		logic [2:0] fix;
		row_exp_t   how;
		logic [7:0] value;
		logic [1:0] status;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        multipart;
	logic [31:0] expected_part_size;
	logic [31:0] expected_part_crc;
	logic [31:0] expected_file_crc;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  decoded_byte;
	logic        byte_valid;
	logic [1:0]  check_status;
	logic        check_valid;

	yenc_byte_decoder_with_crc_check #(
		.LENGTH_WIDTH(LEN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.data_byte(data_byte),
		.multipart(multipart),
		.expected_part_size(expected_part_size),
		.expected_part_crc(expected_part_crc),
		.expected_file_crc(expected_file_crc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.decoded_byte(decoded_byte),
		.byte_valid(byte_valid),
		.check_status(check_status),
		.check_valid(check_valid)
	);

	// Decoder state as the testbench tracks it, plus the two offset registers.
	logic [7:0]       main_ofs;
	logic [7:0]       esc_ofs;
	logic             esc_armed;
	logic [31:0]      part_crc_acc;
	logic [31:0]      file_crc_acc;
	logic [LEN_W-1:0] part_byte_count;

	// Results that accepted items have caused and that have not yet come out.
	res_t     expected_q[$];
	dir_row_t dir_rows[$];
	int       mismatches;

	// Shared between the stimulus and the receiver: calm turns idling off on both
	// sides, and rx_hold_req asks the receiver for one long hold-off.
	bit calm;
	bit rx_hold_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run ends here if the handshakes ever lock up.
	initial begin
		#(TIMEOUT_NS);
		$display("yenc_byte_decoder_with_crc_check: mismatch");
		$finish;
	end

	// Reflected CRC-32 over one byte, shifted in one bit at a time: the feedback
	// bit is the low bit of the register XOR the next data bit, LSB first.
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] v);
		logic [31:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ v[i];
			r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	// Works out the result of one accepted item and moves the tracked state on.
	// Returns 1 when the item causes a result.
	function automatic bit predict_item(input stim_t s, output res_t r);
		logic [7:0] plain;
		r = '0;
		case (s.kind)
			KIND_DATA: begin
				// The byte right after an escape is always decoded, even when
				// it is CR, LF or another escape character.
				if (esc_armed) begin
					plain = s.data - esc_ofs - main_ofs;
					esc_armed = 1'b0;
				end else if (s.data == CH_CR || s.data == CH_LF) begin
					return 1'b0;
				end else if (s.data == CH_ESC) begin
					esc_armed = 1'b1;
					return 1'b0;
				end else begin
					plain = s.data - main_ofs;
				end
				part_crc_acc = crc_step(part_crc_acc, plain);
				file_crc_acc = crc_step(file_crc_acc, plain);
				// The part length sticks at its top value instead of wrapping.
				if (part_byte_count != '1)
					part_byte_count = part_byte_count + 1'b1;
				r.value = plain;
				r.byte_flag = 1'b1;
				return 1'b1;
			end
			KIND_CHECK: begin
				// Size goes before part CRC; the file CRC is looked at only
				// when both part checks passed and a nonzero value was given.
				r.status = STAT_OK;
				if (s.multipart) begin
					if (64'(part_byte_count) != 64'(s.exp_size))
						r.status = STAT_SIZE_ERR;
					else if (~part_crc_acc != s.part_crc)
						r.status = STAT_PART_ERR;
				end
				if (r.status == STAT_OK && s.file_crc != 32'd0 && ~file_crc_acc != s.file_crc)
					r.status = STAT_FILE_ERR;
				r.check_flag = 1'b1;
				// The part state starts over; the file CRC runs on.
				esc_armed = 1'b0;
				part_crc_acc = CRC_INIT;
				part_byte_count = '0;
				return 1'b1;
			end
			KIND_RESTART: begin
				esc_armed = 1'b0;
				part_crc_acc = CRC_INIT;
				part_byte_count = '0;
				file_crc_acc = CRC_INIT;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_row(input logic [1:0] k, input logic [7:0] d, input logic mp,
			input logic [31:0] sz, input logic [31:0] pc, input logic [31:0] fc,
			input logic [2:0] fix, input row_exp_t how, input logic [7:0] v,
			input logic [1:0] st);
		dir_row_t row;
		row.s = '{kind: k, data: d, multipart: mp, exp_size: sz, part_crc: pc, file_crc: fc};
		row.fix = fix;
		row.how = how;
		row.value = v;
		row.status = st;
		dir_rows.push_back(row);
	endfunction

	// Offers one item and returns once it is accepted. It is called at a rising
	// edge, with the previous item (if any) accepted at that same edge, so the
	// payload changes with a single nonblocking write per signal per step.
	// Each cycle the sender stays idle with the idle percentage as chance, unless calm is set.
	task automatic offer_item(input stim_t s, input logic [2:0] fix, output bit got,
			output res_t r);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		// All earlier items are accepted and predicted, so the totals are current.
		if (fix & FIX_SIZE)
			s.exp_size = s.exp_size ^ part_byte_count[31:0];
		if (fix & FIX_PCRC)
			s.part_crc = s.part_crc ^ ~part_crc_acc;
		if (fix & FIX_FCRC)
			s.file_crc = s.file_crc ^ ~file_crc_acc;
		in_valid <= 1'b1;
		kind <= s.kind;
		data_byte <= s.data;
		multipart <= s.multipart;
		expected_part_size <= s.exp_size;
		expected_part_crc <= s.part_crc;
		expected_file_crc <= s.file_crc;
		do @(posedge clk); while (!in_ready);
		got = predict_item(s, r);
	endtask

	// Stops offering, waits for every expected result, then lets the clock run
	// on in case an item that causes no result is still inside.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both offsets while the block is idle.
	task automatic set_offsets(input logic [7:0] m, input logic [7:0] e);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAIN_OFFSET;
		cfg_data <= m;
		@(posedge clk);
		main_ofs = m;
		cfg_index <= CFG_ESCAPE_OFFSET;
		cfg_data <= e;
		@(posedge clk);
		esc_ofs = e;
		cfg_we <= 1'b0;
	endtask

	// Random stimulus. Most of it is whole parts: a run of encoded bytes, with
	// CR, LF and escapes mixed in, closed by a part-end item whose expected
	// values are mostly right or one bit off, and some carry a random file CRC.
	// The rest is restarts, random part-end items and ignored kind 3 items.
	task automatic run_random(input int n);
		int         sent;
		int         len;
		int         pick;
		stim_t      s;
		logic [2:0] fix;
		bit         got;
		res_t       r;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			s.data = $urandom_range(255);
			s.multipart = $urandom_range(1);
			s.exp_size = $urandom();
			s.part_crc = $urandom();
			s.file_crc = $urandom();
			fix = '0;
			if (pick < 80) begin
				// A few long parts, most of them short.
				len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
				repeat (len) begin
					s.kind = KIND_DATA;
					case ($urandom_range(9))
						0: s.data = CH_CR;
						1: s.data = CH_LF;
						2, 3: s.data = CH_ESC;
						default: s.data = $urandom_range(255);
					endcase
					s.exp_size = $urandom();
					offer_item(s, fix, got, r);
					if (got)
						expected_q.push_back(r);
					sent++;
				end
				s.kind = KIND_CHECK;
				fix = FIX_ALL;
				s.exp_size = ($urandom_range(9) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0;
				s.part_crc = ($urandom_range(9) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0;
				case ($urandom_range(3))
					0: begin
						fix = FIX_SIZE | FIX_PCRC;
						s.file_crc = 32'd0;
					end
					1: fix = FIX_SIZE | FIX_PCRC;
					default: begin
						s.file_crc = ($urandom_range(9) == 0) ?
							(32'd1 << $urandom_range(31)) : 32'd0;
					end
				endcase
			end else if (pick < 86) begin
				s.kind = KIND_RESTART;
			end else if (pick < 93) begin
				s.kind = KIND_CHECK;
			end else begin
				s.kind = KIND_UNUSED;
			end
			offer_item(s, fix, got, r);
			if (got)
				expected_q.push_back(r);
			// Ignored items do not count toward the stimulus.
			if (s.kind != KIND_UNUSED)
				sent++;
		end
	endtask

	// Receiver. It stalls at random, never while calm is set, and once holds
	// out_ready low for a long stretch so that the block fills up and stalls
	// its input while the sender keeps offering items.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Every accepted result is compared, field by field, with the oldest
	// expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no item waiting: byte %h/%b status %0d/%b",
						$realtime, decoded_byte, byte_valid, check_status, check_valid);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (decoded_byte !== want.value || byte_valid !== want.byte_flag ||
						check_status !== want.status || check_valid !== want.check_flag) begin
					if (mismatches < 10) begin
						$display("%0t: wrong result: expected byte %h valid %b status %0d check %b",
							$realtime, want.value, want.byte_flag, want.status,
							want.check_flag);
						$display("    got byte %h valid %b status %0d check %b",
							decoded_byte, byte_valid, check_status, check_valid);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		bit         got;
		res_t       r;
		res_t       typed;
		logic [7:0] m;
		logic [7:0] e;

		mismatches = 0;
		calm = 1'b0;
		rx_hold_req = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MAIN_OFFSET;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_DATA;
		data_byte <= '0;
		multipart <= 1'b0;
		expected_part_size <= '0;
		expected_part_crc <= '0;
		expected_file_crc <= '0;

		main_ofs = MAIN_OFFSET_RST;
		esc_ofs = ESCAPE_OFFSET_RST;
		esc_armed = 1'b0;
		part_crc_acc = CRC_INIT;
		file_crc_acc = CRC_INIT;
		part_byte_count = '0;

		// Directed items, run with the offsets as they come out of reset (42
		// and 64). The first rows show plain decoding at both ends of the
		// byte range and the dropped CR, LF and escape characters.
		add_row(KIND_DATA, 8'h2A, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'h00, STAT_OK);
		add_row(KIND_DATA, 8'h29, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'hFF, STAT_OK);
		add_row(KIND_DATA, 8'hFF, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'hD5, STAT_OK);
		add_row(KIND_DATA, CH_CR, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_DATA, CH_LF, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		// An escaped CR, LF and escape character are all decoded, with both
		// offsets taken off.
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_DATA, CH_CR, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'hA3, STAT_OK);
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_DATA, CH_LF, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'hA0, STAT_OK);
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'hD3, STAT_OK);
		// Six bytes in the part against an all-ones size: the size check
		// fails first, whatever the CRCs say.
		add_row(KIND_CHECK, 8'h00, 1'b1, '1, '1, '1, '0, EXP_STATUS, '0, STAT_SIZE_ERR);
		// Right size, part CRC off by one bit.
		add_row(KIND_DATA, 8'h80, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'h56, STAT_OK);
		add_row(KIND_CHECK, 8'h00, 1'b1, '0, 32'd1, '0, FIX_SIZE | FIX_PCRC, EXP_STATUS, '0,
			STAT_PART_ERR);
		// Single part, no file CRC given: nothing to check.
		add_row(KIND_CHECK, 8'h00, 1'b0, '1, '1, '0, '0, EXP_STATUS, '0, STAT_OK);
		// An escape left open at a part end is dropped with the part state.
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_CHECK, 8'h00, 1'b1, '0, '0, '0, FIX_ALL, EXP_STATUS, '0, STAT_OK);
		add_row(KIND_DATA, 8'h2B, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'h01, STAT_OK);
		// Part checks pass, file CRC off by its top bit.
		add_row(KIND_CHECK, 8'h00, 1'b1, '0, '0, 32'h8000_0000, FIX_ALL, EXP_PREDICT, '0,
			STAT_OK);
		add_row(KIND_UNUSED, 8'hFF, 1'b1, '1, '1, '1, '0, EXP_NONE, '0, STAT_OK);
		// A restart also drops an open escape.
		add_row(KIND_DATA, CH_ESC, 1'b0, '0, '0, '0, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_RESTART, 8'hFF, 1'b1, '1, '1, '1, '0, EXP_NONE, '0, STAT_OK);
		add_row(KIND_DATA, 8'h2A, 1'b0, '0, '0, '0, '0, EXP_BYTE, 8'h00, STAT_OK);
		add_row(KIND_CHECK, 8'h00, 1'b1, '0, '0, '0, FIX_ALL, EXP_STATUS, '0, STAT_OK);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			offer_item(dir_rows[i].s, dir_rows[i].fix, got, r);
			typed = '0;
			case (dir_rows[i].how)
				EXP_PREDICT: begin
					if (got)
						expected_q.push_back(r);
				end
				EXP_BYTE: begin
					typed.value = dir_rows[i].value;
					typed.byte_flag = 1'b1;
					expected_q.push_back(typed);
				end
				EXP_STATUS: begin
					typed.status = dir_rows[i].status;
					typed.check_flag = 1'b1;
					expected_q.push_back(typed);
				end
				default: ;
			endcase
		end

		// Random phases, each under its own offsets. Every phase starts with
		// the sender paused until all expected results are in. One phase runs
		// with no idling on either side, and one opens with the long
		// hold-off at the receiver.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					m = 8'h00;
					e = 8'h00;
				end
				1: begin
					m = 8'hFF;
					e = 8'hFF;
				end
				3: begin
					m = MAIN_OFFSET_RST;
					e = ESCAPE_OFFSET_RST;
				end
				5: begin
					m = 8'h01;
					e = 8'h80;
				end
				default: begin
					m = $urandom_range(255);
					e = $urandom_range(255);
				end
			endcase
			set_offsets(m, e);
			calm = (p == 3);
			if (p == 4)
				rx_hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end
		calm = 1'b0;

		drain_pipeline();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("yenc_byte_decoder_with_crc_check: match");
		else
			$display("yenc_byte_decoder_with_crc_check: mismatch");
		$finish;
	end

endmodule
